>>> hw/rtl/rtu_flc_pkg.sv
// Package for the Modbus RTU frame length checker.
// Holds verdict and error codes, function codes and length limits; no dependencies.
package rtu_flc_pkg;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_MORE = 2'd1,
      STATUS_ERR  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ERR_NONE       = 3'd0,
      ERR_BROADCAST  = 3'd1,
      ERR_BYTE_COUNT = 3'd2,
      ERR_REG_COUNT  = 3'd3,
      ERR_FUNCTION   = 3'd4,
      ERR_TOO_LONG   = 3'd5
   } error_type;

   localparam logic [7:0] FC_READ_HOLDING  = 8'h03;
   localparam logic [7:0] FC_READ_INPUT    = 8'h04;
   localparam logic [7:0] FC_WRITE_SINGLE  = 8'h06;
   localparam logic [7:0] FC_WRITE_MULTI   = 8'h10;
   localparam int unsigned EXCEPTION_BIT   = 7;

   localparam logic [8:0] COUNT_MAX        = 9'd256;
   localparam logic [8:0] MIN_FRAME_LEN    = 9'd5;
   localparam logic [8:0] EXCEPTION_LEN    = 9'd5;
   localparam logic [8:0] FIXED_LEN        = 9'd8;
   localparam logic [8:0] READ_REPLY_BASE  = 9'd5;
   localparam logic [8:0] WRITE_MULTI_BASE = 9'd9;
   localparam logic [7:0] MAX_BYTE_COUNT   = 8'd250;
   localparam logic [15:0] MAX_QUANTITY    = 16'd123;

   // byte positions captured from the frame header
   localparam logic [8:0] POS_ADDRESS      = 9'd0;
   localparam logic [8:0] POS_FUNCTION     = 9'd1;
   localparam logic [8:0] POS_COUNT        = 9'd2;
   localparam logic [8:0] POS_QTY_HIGH     = 9'd4;
   localparam logic [8:0] POS_QTY_LOW      = 9'd5;

endpackage

>>> hw/rtl/rtu_flc_if.sv
// Valid/ready channels of the frame length checker: byte words in, verdict words out.
// Depends on rtu_flc_pkg for the verdict types.
interface rtu_flc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last;

   modport source (output valid, output data_byte, output last, input ready);
   modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface rtu_flc_rsp_if;
   logic                   valid;
   logic                   ready;
   rtu_flc_pkg::status_type status;
   rtu_flc_pkg::error_type  error_kind;
   logic [7:0]             frame_length;
   logic [7:0]             slave_address;
   logic [7:0]             function_code;

   modport source (output valid, output status, output error_kind, output frame_length,
                   output slave_address, output function_code, input ready);
   modport sink   (input valid, input status, input error_kind, input frame_length,
                   input slave_address, input function_code, output ready);
endinterface

>>> hw/rtl/rtu_frame_length_checker.sv
// Top level of the Modbus RTU frame length checker.
// Depends on rtu_flc_pkg and the channel interfaces in rtu_flc_if.sv.
//
//   channel   direction  word                         words per frame
//   req_bus   in         data_byte, last              one per frame byte
//   rsp_bus   out        status, error_kind,          one, on the last byte
//                        frame_length, slave_address,
//                        function_code
//
// One byte word is accepted per cycle while req_bus is not stalled. A word is
// held in the input register, then the frame state is updated and, on the last
// byte, the verdict is judged and written to the result register, which offers
// it on rsp_bus. The whole pipe advances whenever the result register is empty
// or being taken, so a stalled verdict stalls req_bus.
// Synchronous reset empties both registers and clears the frame state.
module rtu_frame_length_checker (
   input  logic         clock,
   input  logic         reset,
   rtu_flc_req_if.sink  req_bus,
   rtu_flc_rsp_if.source rsp_bus
);
   import rtu_flc_pkg::*;

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // frame state
   logic [8:0] count_ff, count_in;
   logic       odd_ff, odd_in;
   logic [7:0] addr_ff, addr_in;
   logic [7:0] func_ff, func_in;
   logic [7:0] bcnt_ff, bcnt_in;
   logic [7:0] qhi_ff, qhi_in;
   logic [7:0] qlo_ff, qlo_in;

   // result register
   logic       rsp_valid_ff;
   status_type status_ff, status_in;
   error_type  kind_ff, kind_in;
   logic [7:0] flen_ff, flen_in;
   logic [7:0] raddr_ff;
   logic [7:0] rfunc_ff;

   logic       advance;
   logic       fire;
   logic [8:0] expect_len;
   logic       check_len;
   logic [15:0] quantity;

   // advance the pipe while the result register is free or being taken
   assign advance        = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready  = advance;
   assign fire           = in_valid_ff && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_bus.valid;
      end
      if (advance) begin
         in_byte_ff <= req_bus.data_byte;
         in_last_ff <= req_bus.last;
      end
   end

   // Frame state after this byte: count saturates, parity keeps the true length,
   // header bytes land in their slots by position.
   always_comb begin
      count_in = (count_ff == COUNT_MAX) ? count_ff : count_ff + 9'd1;
      odd_in   = ~odd_ff;
      addr_in  = (count_ff == POS_ADDRESS)  ? in_byte_ff : addr_ff;
      func_in  = (count_ff == POS_FUNCTION) ? in_byte_ff : func_ff;
      bcnt_in  = (count_ff == POS_COUNT)    ? in_byte_ff : bcnt_ff;
      qhi_in   = (count_ff == POS_QTY_HIGH) ? in_byte_ff : qhi_ff;
      qlo_in   = (count_ff == POS_QTY_LOW)  ? in_byte_ff : qlo_ff;
   end

   assign quantity = {qhi_in, qlo_in};

   // Verdict on the updated state. Odd length on read/write-multiple codes
   // marks a reply or a write request carrying data.
   always_comb begin
      status_in  = STATUS_MORE;
      kind_in    = ERR_NONE;
      flen_in    = 8'd0;
      expect_len = 9'd0;
      check_len  = 1'b0;
      if (count_in < MIN_FRAME_LEN) begin
         status_in = STATUS_MORE;
      end else if (addr_in == 8'd0) begin
         status_in = STATUS_ERR;
         kind_in   = ERR_BROADCAST;
      end else if (func_in[EXCEPTION_BIT]) begin
         expect_len = EXCEPTION_LEN;
         check_len  = 1'b1;
      end else begin
         case (func_in) inside
            FC_READ_HOLDING, FC_READ_INPUT: begin
               if (!odd_in) begin
                  expect_len = FIXED_LEN;
                  check_len  = 1'b1;
               end else if (bcnt_in == 8'd0 || bcnt_in[0] || bcnt_in > MAX_BYTE_COUNT) begin
                  status_in = STATUS_ERR;
                  kind_in   = ERR_BYTE_COUNT;
               end else begin
                  expect_len = READ_REPLY_BASE + {1'b0, bcnt_in};
                  check_len  = 1'b1;
               end
            end
            FC_WRITE_SINGLE: begin
               expect_len = FIXED_LEN;
               check_len  = 1'b1;
            end
            FC_WRITE_MULTI: begin
               if (!odd_in) begin
                  expect_len = FIXED_LEN;
                  check_len  = 1'b1;
               end else if (count_in == MIN_FRAME_LEN) begin
                  // quantity not complete yet
                  status_in = STATUS_MORE;
               end else if (quantity == 16'd0 || quantity > MAX_QUANTITY) begin
                  status_in = STATUS_ERR;
                  kind_in   = ERR_REG_COUNT;
               end else begin
                  // quantity fits in 7 bits here, so 2q fits in 9
                  expect_len = WRITE_MULTI_BASE + {quantity[7:0], 1'b0};
                  check_len  = 1'b1;
               end
            end
            default: begin
               status_in = STATUS_ERR;
               kind_in   = ERR_FUNCTION;
            end
         endcase
      end
      if (check_len) begin
         if (count_in < expect_len) begin
            status_in = STATUS_MORE;
         end else if (count_in > expect_len) begin
            status_in = STATUS_ERR;
            kind_in   = ERR_TOO_LONG;
         end else begin
            status_in = STATUS_OK;
            flen_in   = expect_len[7:0];
         end
      end
   end

   // update the frame state; drop it back to zero after the last byte
   always_ff @(posedge clock) begin
      if (reset || (fire && in_last_ff)) begin
         count_ff <= '0;
         odd_ff   <= 1'b0;
         addr_ff  <= '0;
         func_ff  <= '0;
         bcnt_ff  <= '0;
         qhi_ff   <= '0;
         qlo_ff   <= '0;
      end else if (fire) begin
         count_ff <= count_in;
         odd_ff   <= odd_in;
         addr_ff  <= addr_in;
         func_ff  <= func_in;
         bcnt_ff  <= bcnt_in;
         qhi_ff   <= qhi_in;
         qlo_ff   <= qlo_in;
      end
   end

   // result register: load on the last byte, hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff && in_last_ff;
      end
      if (fire && in_last_ff) begin
         status_ff <= status_in;
         kind_ff   <= kind_in;
         flen_ff   <= flen_in;
         raddr_ff  <= addr_in;
         rfunc_ff  <= func_in;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = status_ff;
   assign rsp_bus.error_kind    = kind_ff;
   assign rsp_bus.frame_length  = flen_ff;
   assign rsp_bus.slave_address = raddr_ff;
   assign rsp_bus.function_code = rfunc_ff;

endmodule

>>> hw/rtl/rtu_flc_checker.sv
// Port-level assertions for the frame length checker, bound to its top level.
// Depends on rtu_flc_pkg and rtu_frame_length_checker.
module rtu_flc_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input rtu_flc_pkg::status_type rsp_status,
   input rtu_flc_pkg::error_type  rsp_error_kind,
   input logic [7:0]              rsp_frame_length
);
   import rtu_flc_pkg::*;

   // reset empties the result register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("verdict valid right after reset");

   // hold a stalled verdict
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_error_kind) && $stable(rsp_frame_length))
      else $error("stalled verdict changed");

   // a stalled verdict blocks new bytes
   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("byte accepted while verdict stalled");

   // an ok verdict carries a real length and no error
   a_ok_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OK |->
         rsp_error_kind == ERR_NONE && rsp_frame_length >= 8'd5)
      else $error("ok verdict with bad fields");

   // a non-ok verdict has zero length
   a_notok_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_frame_length == 8'd0)
      else $error("length given without ok verdict");

endmodule

bind rtu_frame_length_checker rtu_flc_checker u_rtu_flc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_status       (rsp_bus.status),
   .rsp_error_kind   (rsp_bus.error_kind),
   .rsp_frame_length (rsp_bus.frame_length)
);
